// ----- hw/rtl/apc_pkg.sv -----
`default_nettype none

package apc_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int COUNT_WIDTH = 16;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CUR_W   = ((ADDR_W > 16) ? ADDR_W : 16) + 1;
    localparam int ENTRY_W = 3 * COUNT_WIDTH;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = COUNT_WIDTH + 1 + PCT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PCT_SCALE = 100;

    localparam logic [PCT_W-1:0] MATCH_PCT_RESET  = PCT_W'(80);
    localparam logic [PCT_W-1:0] DELETE_PCT_RESET = PCT_W'(40);

    localparam logic CFG_MATCH_PCT  = 1'b0;
    localparam logic CFG_DELETE_PCT = 1'b1;

    localparam int SYM_GAP_BIT = 2;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_MATCH,
        KIND_INSERT,
        KIND_DELETE,
        KIND_READ
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISMATCH,
        ST_RANGE,
        ST_DEL_ZERO
    } t_status;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic               clr;
        logic [ADDR_W-1:0]  addr;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [15:0] clamp16(input logic [COUNT_WIDTH-1:0] v);
        return (v > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF : 16'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/apc_in_if.sv -----
`default_nettype none

interface apc_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        start_flag;
    logic [15:0] start_offset;
    logic [2:0]  query_sym;
    logic [2:0]  subject_sym;
    logic [15:0] position;
    logic        clear_after_read;

    modport source (
        output valid, req_type, start_flag, start_offset, query_sym, subject_sym,
               position, clear_after_read,
        input  ready
    );

    modport sink (
        input  valid, req_type, start_flag, start_offset, query_sym, subject_sym,
               position, clear_after_read,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/apc_out_if.sv -----
`default_nettype none

interface apc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_count;
    logic [15:0] insert_count;
    logic [15:0] delete_count;
    logic        match_flag;
    logic        insert_flag;
    logic        undecided_flag;
    logic        delete_flag;
    logic [1:0]  status;

    modport source (
        output valid, match_count, insert_count, delete_count, match_flag, insert_flag,
               undecided_flag, delete_flag, status,
        input  ready
    );

    modport sink (
        input  valid, match_count, insert_count, delete_count, match_flag, insert_flag,
               undecided_flag, delete_flag, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/apc_ram.sv -----
`default_nettype none

module apc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/apc_front.sv -----
`default_nettype none

module apc_front
    import apc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    apc_in_if.sink          in_ch,
    input  wire logic       i_push_ready,
    input  wire t_back_stat i_back_stat,
    output t_push           o_push
);

    logic [CUR_W-1:0] r_cursor;
    logic             r_in_run;
    logic [CUR_W-1:0] n_cursor;
    logic             n_in_run;
    t_op              w_op;
    logic             w_accept;

    assign in_ch.ready = i_push_ready && !i_back_stat.clearing;
    assign w_accept    = in_ch.valid && in_ch.ready;

    always_comb begin
        logic qgap;
        logic sgap;
        qgap     = in_ch.query_sym[SYM_GAP_BIT];
        sgap     = in_ch.subject_sym[SYM_GAP_BIT];
        n_cursor = r_cursor;
        n_in_run = r_in_run;
        w_op.kind   = KIND_NONE;
        w_op.status = ST_OK;
        w_op.clr    = 1'b0;
        w_op.addr   = '0;
        if (in_ch.req_type) begin
            w_op.clr  = in_ch.clear_after_read;
            w_op.addr = ADDR_W'(in_ch.position);
            if (32'(in_ch.position) >= 32'(TABLE_DEPTH)) begin
                w_op.status = ST_RANGE;
            end else begin
                w_op.kind = KIND_READ;
            end
        end else begin
            if (in_ch.start_flag) begin
                n_cursor = CUR_W'(in_ch.start_offset);
                n_in_run = 1'b0;
            end
            if (sgap && n_in_run) begin
                w_op.kind = KIND_NONE;
            end else if (qgap && sgap) begin
                w_op.kind = KIND_NONE;
            end else if (sgap) begin
                n_in_run  = 1'b1;
                w_op.addr = ADDR_W'(n_cursor - CUR_W'(1));
                if (n_cursor == '0) begin
                    w_op.status = ST_DEL_ZERO;
                end else if (32'(n_cursor) > 32'(TABLE_DEPTH)) begin
                    w_op.status = ST_RANGE;
                end else begin
                    w_op.kind = KIND_DELETE;
                end
            end else begin
                n_in_run  = 1'b0;
                w_op.addr = ADDR_W'(n_cursor);
                if (!qgap && (in_ch.query_sym != in_ch.subject_sym)) begin
                    w_op.status = ST_MISMATCH;
                end else if (32'(n_cursor) >= 32'(TABLE_DEPTH)) begin
                    w_op.status = ST_RANGE;
                end else begin
                    w_op.kind = qgap ? KIND_INSERT : KIND_MATCH;
                    n_cursor  = n_cursor + CUR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_in_run <= 1'b0;
        end else if (w_accept) begin
            r_cursor <= n_cursor;
            r_in_run <= n_in_run;
        end
    end

    assign o_push.valid = w_accept;
    assign o_push.op    = w_op;

endmodule

`default_nettype wire

// ----- hw/rtl/apc_queue.sv -----
`default_nettype none

module apc_queue
    import apc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_push_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_op        o_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_op         = r_mem[r_rptr];
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/apc_back.sv -----
`default_nettype none

module apc_back
    import apc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [PCT_W-1:0] i_match_pct,
    input  wire logic [PCT_W-1:0] i_delete_pct,
    input  wire logic             i_q_valid,
    input  wire t_op              i_q_op,
    output logic                  o_q_pop,
    output t_back_stat            o_back_stat,
    apc_out_if.source             out_ch
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CMP
    } t_state;

    t_state                  r_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    t_op                     r_op;
    logic [COUNT_WIDTH-1:0]  r_m;
    logic [COUNT_WIDTH-1:0]  r_i;
    logic [COUNT_WIDTH-1:0]  r_d;
    logic [PROD_W-1:0]       r_pm;
    logic [PROD_W-1:0]       r_pi;
    logic [PROD_W-1:0]       r_pd;
    logic [PROD_W-1:0]       r_pcm;
    logic [PROD_W-1:0]       r_pcd;
    logic                    r_out_valid;
    logic [15:0]             r_out_m;
    logic [15:0]             r_out_i;
    logic [15:0]             r_out_d;
    logic                    r_out_mf;
    logic                    r_out_if;
    logic                    r_out_uf;
    logic                    r_out_df;
    t_status                 r_out_st;

    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [ENTRY_W-1:0]      n_entry;
    logic [ENTRY_W-1:0]      w_rdata;
    logic [COUNT_WIDTH-1:0]  w_m;
    logic [COUNT_WIDTH-1:0]  w_i;
    logic [COUNT_WIDTH-1:0]  w_d;
    logic [COUNT_WIDTH:0]    w_cov;
    logic                    w_out_free;
    logic                    w_mf;
    logic                    w_if;

    assign w_m   = w_rdata[3*COUNT_WIDTH-1:2*COUNT_WIDTH];
    assign w_i   = w_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign w_d   = w_rdata[COUNT_WIDTH-1:0];
    assign w_cov = (COUNT_WIDTH+1)'(w_m) + (COUNT_WIDTH+1)'(w_i);

    assign w_out_free = !r_out_valid || out_ch.ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_back_stat.clearing = (r_state == S_CLEAR);

    assign w_mf = (r_pm >= r_pcm);
    assign w_if = (r_pi >= r_pcm);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_op.addr;
        n_entry = w_rdata;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            n_entry = '0;
        end else if (r_state == S_RD) begin
            unique case (r_op.kind)
                KIND_MATCH: begin
                    w_we    = 1'b1;
                    n_entry = {bump(w_m), w_i, w_d};
                end
                KIND_INSERT: begin
                    w_we    = 1'b1;
                    n_entry = {w_m, bump(w_i), w_d};
                end
                KIND_DELETE: begin
                    w_we    = 1'b1;
                    n_entry = {w_m, w_i, bump(w_d)};
                end
                KIND_READ: begin
                    w_we    = r_op.clr;
                    n_entry = '0;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    apc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (n_entry),
        .i_raddr (i_q_op.addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_CMP) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op    <= i_q_op;
                        r_state <= (i_q_op.kind == KIND_NONE) ? S_CMP : S_RD;
                    end
                end
                S_RD: begin
                    r_m     <= w_m;
                    r_i     <= w_i;
                    r_d     <= w_d;
                    r_pm    <= PROD_W'(w_m) * PROD_W'(PCT_SCALE);
                    r_pi    <= PROD_W'(w_i) * PROD_W'(PCT_SCALE);
                    r_pd    <= PROD_W'(w_d) * PROD_W'(PCT_SCALE);
                    r_pcm   <= PROD_W'(w_cov) * PROD_W'(i_match_pct);
                    r_pcd   <= PROD_W'(w_cov) * PROD_W'(i_delete_pct);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_out_free) begin
                        r_out_st    <= r_op.status;
                        if (r_op.kind == KIND_READ) begin
                            r_out_m  <= clamp16(r_m);
                            r_out_i  <= clamp16(r_i);
                            r_out_d  <= clamp16(r_d);
                            r_out_mf <= w_mf;
                            r_out_if <= w_if;
                            r_out_uf <= !w_mf && !w_if;
                            r_out_df <= (r_pd >= r_pcd);
                        end else begin
                            r_out_m  <= '0;
                            r_out_i  <= '0;
                            r_out_d  <= '0;
                            r_out_mf <= 1'b0;
                            r_out_if <= 1'b0;
                            r_out_uf <= 1'b0;
                            r_out_df <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid          = r_out_valid;
    assign out_ch.match_count    = r_out_m;
    assign out_ch.insert_count   = r_out_i;
    assign out_ch.delete_count   = r_out_d;
    assign out_ch.match_flag     = r_out_mf;
    assign out_ch.insert_flag    = r_out_if;
    assign out_ch.undecided_flag = r_out_uf;
    assign out_ch.delete_flag    = r_out_df;
    assign out_ch.status         = r_out_st;

endmodule

`default_nettype wire

// ----- hw/rtl/alignment_pileup_counter.sv -----
`default_nettype none

// Pileup counter: alignment columns and position reads enter on in_ch, one result per
// transaction leaves on out_ch in order. The front end takes a transaction every cycle
// while the queue has room and the RAM is not being cleared, updates the cursor and
// deletion-run state, and parks the classified operation in a four-entry queue. The back
// end drains it one operation at a time through the simple dual-port count RAM (RAM
// read, write-back and product stage, compare); an operation that touches no entry skips
// the write-back and product stage. The next one is popped only once the last leaves
// compare, which waits while out_ch is stalled. After reset the RAM is zeroed one entry
// per cycle, all TABLE_DEPTH (65536) entries, with in_ch.ready low; configuration writes are taken at any time.
module alignment_pileup_counter
    import apc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    apc_in_if.sink                in_ch,
    apc_out_if.source             out_ch,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [PCT_W-1:0] i_cfg_data
);

    logic [PCT_W-1:0] r_match_pct;
    logic [PCT_W-1:0] r_delete_pct;
    t_push            w_push;
    logic             w_push_ready;
    logic             w_q_valid;
    t_op              w_q_op;
    logic             w_q_pop;
    t_back_stat       w_back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_pct  <= MATCH_PCT_RESET;
            r_delete_pct <= DELETE_PCT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATCH_PCT:  r_match_pct  <= i_cfg_data;
                CFG_DELETE_PCT: r_delete_pct <= i_cfg_data;
                default:        r_match_pct  <= r_match_pct;
            endcase
        end
    end

    apc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .i_push_ready (w_push_ready),
        .i_back_stat  (w_back_stat),
        .o_push       (w_push)
    );

    apc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_pop        (w_q_pop),
        .o_valid      (w_q_valid),
        .o_op         (w_q_op)
    );

    apc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_match_pct  (r_match_pct),
        .i_delete_pct (r_delete_pct),
        .i_q_valid    (w_q_valid),
        .i_q_op       (w_q_op),
        .o_q_pop      (w_q_pop),
        .o_back_stat  (w_back_stat),
        .out_ch       (out_ch)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/apc_checker.sv -----
`default_nettype none

module apc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_match_count,
    input wire logic [15:0] i_insert_count,
    input wire logic [15:0] i_delete_count,
    input wire logic        i_match_flag,
    input wire logic        i_insert_flag,
    input wire logic        i_undecided_flag,
    input wire logic        i_delete_flag,
    input wire logic [1:0]  i_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_match_count) && $stable(i_insert_count) && $stable(i_delete_count))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("channel active right after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != 2'd0) |-> (i_match_count == 16'd0)
            && (i_insert_count == 16'd0) && (i_delete_count == 16'd0)
            && !i_match_flag && !i_insert_flag && !i_undecided_flag && !i_delete_flag)
        else $error("error result carries counts or flags");

    a_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == 2'd0) && (i_match_flag || i_insert_flag)
            |-> !i_undecided_flag)
        else $error("undecided set with a class flag");

endmodule

bind alignment_pileup_counter apc_checker u_apc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (in_ch.ready),
    .i_out_valid      (out_ch.valid),
    .i_out_ready      (out_ch.ready),
    .i_match_count    (out_ch.match_count),
    .i_insert_count   (out_ch.insert_count),
    .i_delete_count   (out_ch.delete_count),
    .i_match_flag     (out_ch.match_flag),
    .i_insert_flag    (out_ch.insert_flag),
    .i_undecided_flag (out_ch.undecided_flag),
    .i_delete_flag    (out_ch.delete_flag),
    .i_status         (out_ch.status)
);

`default_nettype wire
